// ===== src/tlb_pkg.sv =====
`default_nettype none

package tlb_pkg;

    // Index and age fields are sized for the largest supported store (64 entries).
    localparam int TLB_IDX_W = 6;

    // Priority chain carried from cell to cell, lowest index first.
    typedef struct packed {
        logic                 hit_found;
        logic [TLB_IDX_W-1:0] hit_idx;
        logic [TLB_IDX_W-1:0] hit_age;
        logic                 empty_found;
        logic [TLB_IDX_W-1:0] empty_idx;
        logic                 lru_found;
        logic [TLB_IDX_W-1:0] lru_idx;
    } t_chain;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic                 upd;
        logic                 hit;
        logic [TLB_IDX_W-1:0] slot;
        logic [TLB_IDX_W-1:0] old_age;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/tlb_cell.sv =====
`default_nettype none

module tlb_cell import tlb_pkg::*; #(
    parameter int ENTRIES = 8,
    parameter int INDEX   = 0,
    parameter int PW      = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [PW-1:0] i_page,
    input  wire t_cmd          i_cmd,
    input  wire t_chain        i_chain,
    output t_chain             o_chain
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] AGE_MAX = AW'(ENTRIES - 1);
    localparam logic [TLB_IDX_W-1:0] IDX = TLB_IDX_W'(INDEX);

    logic          r_valid;
    logic [PW-1:0] r_page;
    logic [AW-1:0] r_age;
    logic          n_valid;
    logic [AW-1:0] n_age;

    logic match;
    logic sel;

    assign match = r_valid && (r_page == i_page);
    assign sel   = (i_cmd.slot[AW-1:0] == AW'(INDEX));

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.hit_found && match) begin
            o_chain.hit_found = 1'b1;
            o_chain.hit_idx   = IDX;
            o_chain.hit_age   = TLB_IDX_W'(r_age);
        end
        if (!i_chain.empty_found && !r_valid) begin
            o_chain.empty_found = 1'b1;
            o_chain.empty_idx   = IDX;
        end
        if (!i_chain.lru_found && r_valid && (r_age == AGE_MAX)) begin
            o_chain.lru_found = 1'b1;
            o_chain.lru_idx   = IDX;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        if (i_cmd.upd) begin
            if (sel) begin
                n_valid = 1'b1;
                n_age   = '0;
            end else if (r_valid && (r_age != AGE_MAX)
                         && (!i_cmd.hit || (r_age < i_cmd.old_age[AW-1:0]))) begin
                n_age = r_age + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && sel && !i_cmd.hit) begin
            r_page <= i_page;
        end
    end

endmodule

`default_nettype wire

// ===== src/tlb_lookup_lru_fill.sv =====
`default_nettype none

// Channel | Handshake                  | Payload
// --------+----------------------------+----------------------------------------------
// input   | i_in_valid / o_in_ready    | i_virtual_address
// output  | o_out_valid / i_out_ready  | o_hit, o_evicted, o_slot, o_page_number,
//         |                            | o_page_offset
//
// An item is registered in the address register, then the cell row compares,
// picks the slot and updates in the same cycle; result appears the cycle after.
// Sustained rate is one item per cycle while results are taken, bounded by the priority chain across cells.
// Synchronous reset clears all valid bits and ages; no clearing pass.
// A stalled result holds the compute step; one item waits behind it.

module tlb_lookup_lru_fill import tlb_pkg::*; #(
    parameter int ENTRIES     = 8,
    parameter int OFFSET_BITS = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [31:0]                      i_virtual_address,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_hit,
    output logic                                  o_evicted,
    output logic [$clog2(ENTRIES)-1:0]            o_slot,
    output logic [32-OFFSET_BITS-1:0]             o_page_number,
    output logic [OFFSET_BITS-1:0]                o_page_offset
);

    localparam int AW = $clog2(ENTRIES);
    localparam int PW = 32 - OFFSET_BITS;

    logic        r_busy;
    logic [31:0] r_addr;
    logic        r_out_valid;
    logic        go;

    t_chain chain [0:ENTRIES];
    t_cmd   cmd;
    t_chain res;

    logic          hit;
    logic          evicted;
    logic [AW-1:0] slot;

    assign go         = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || go;
    assign o_out_valid = r_out_valid;

    assign chain[0] = '0;
    assign res      = chain[ENTRIES];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            tlb_cell #(
                .ENTRIES (ENTRIES),
                .INDEX   (g),
                .PW      (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_page  (r_addr[31:OFFSET_BITS]),
                .i_cmd   (cmd),
                .i_chain (chain[g]),
                .o_chain (chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        hit     = res.hit_found;
        evicted = !res.hit_found && !res.empty_found;
        if (res.hit_found) begin
            slot = res.hit_idx[AW-1:0];
        end else if (res.empty_found) begin
            slot = res.empty_idx[AW-1:0];
        end else if (res.lru_found) begin
            slot = res.lru_idx[AW-1:0];
        end else begin
            slot = '0;
        end
        cmd.upd     = go;
        cmd.hit     = hit;
        cmd.slot    = TLB_IDX_W'(slot);
        cmd.old_age = res.hit_age;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_busy <= 1'b1;
            end else if (go) begin
                r_busy <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_addr <= i_virtual_address;
        end
        if (go) begin
            o_hit         <= hit;
            o_evicted     <= evicted;
            o_slot        <= slot;
            o_page_number <= r_addr[31:OFFSET_BITS];
            o_page_offset <= r_addr[OFFSET_BITS-1:0];
        end
    end

    // A full store always holds exactly one entry at the oldest age.
    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !res.hit_found && !res.empty_found) |-> res.lru_found)
        else $error("no victim in a full store");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_busy)
        else $error("accepted transfer not held");

    a_go_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> r_out_valid)
        else $error("lookup produced no result");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 8;
    localparam int OFFSET_BITS = 12;
    localparam int N_RANDOM    = 1230;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [2:0]  slot;
        logic [19:0] page_number;
        logic [11:0] page_offset;
    } t_xlate;

    typedef struct packed {
        logic [31:0] va;
        logic        known;
        t_xlate      res;
    } t_stim_row;

    // known rows carry the result read off directly; the rest go through the predictor
    localparam int N_ROWS = 20;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        '{32'h0000_0000, 1'b1, '{1'b0, 1'b0, 3'd0, 20'h00000, 12'h000}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 3'd1, 20'hFFFFF, 12'hFFF}},
        '{32'h0000_0FFF, 1'b1, '{1'b1, 1'b0, 3'd0, 20'h00000, 12'hFFF}},
        '{32'hFFFF_F000, 1'b1, '{1'b1, 1'b0, 3'd1, 20'hFFFFF, 12'h000}},
        '{32'h0000_2001, 1'b1, '{1'b0, 1'b0, 3'd2, 20'h00002, 12'h001}},
        '{32'h0000_3002, 1'b1, '{1'b0, 1'b0, 3'd3, 20'h00003, 12'h002}},
        '{32'h0000_4004, 1'b1, '{1'b0, 1'b0, 3'd4, 20'h00004, 12'h004}},
        '{32'h0000_5008, 1'b1, '{1'b0, 1'b0, 3'd5, 20'h00005, 12'h008}},
        '{32'h0000_6010, 1'b1, '{1'b0, 1'b0, 3'd6, 20'h00006, 12'h010}},
        '{32'h0000_7020, 1'b1, '{1'b0, 1'b0, 3'd7, 20'h00007, 12'h020}},
        // store full: oldest entries go first
        '{32'hAAAA_A555, 1'b1, '{1'b0, 1'b1, 3'd0, 20'hAAAAA, 12'h555}},
        '{32'h5555_5AAA, 1'b1, '{1'b0, 1'b1, 3'd1, 20'h55555, 12'hAAA}},
        '{32'h0000_4800, 1'b0, '0},
        '{32'hAAAA_A000, 1'b0, '0},
        '{32'h1234_5678, 1'b0, '0},
        '{32'h0000_2FFF, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'h1234_5ABC, 1'b0, '0},
        '{32'h0000_7000, 1'b0, '0}
    };

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic [31:0] i_virtual_address = '0;
    logic        i_out_ready       = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_hit;
    logic        o_evicted;
    logic [2:0]  o_slot;
    logic [19:0] o_page_number;
    logic [11:0] o_page_offset;

    tlb_lookup_lru_fill #(
        .ENTRIES    (ENTRIES),
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_virtual_address(i_virtual_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_slot           (o_slot),
        .o_page_number    (o_page_number),
        .o_page_offset    (o_page_offset)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the tag store
    logic        tag_valid [ENTRIES];
    logic [19:0] tag_page  [ENTRIES];
    logic [2:0]  tag_age   [ENTRIES];

    t_xlate      pending_xlate [$];
    t_xlate      cur_row_res   = '0;
    logic        cur_row_known = 1'b0;
    logic        calm          = 1'b0;
    int          mismatches    = 0;
    int          cycles        = 0;
    t_xlate      head;

    function automatic t_xlate xlate(logic [31:0] va);
        int     hit_i;
        int     empty_i;
        int     lru_i;
        int     lru_age;
        int     s;
        int     thr;
        t_xlate r;
        hit_i   = -1;
        empty_i = -1;
        lru_i   = -1;
        lru_age = 0;
        r       = '0;
        r.page_number = va[31:12];
        r.page_offset = va[11:0];
        for (int i = 0; i < ENTRIES; i++) begin
            if (tag_valid[i]) begin
                if (hit_i < 0 && tag_page[i] == va[31:12])
                    hit_i = i;
                if (lru_i < 0 || int'(tag_age[i]) > lru_age) begin
                    lru_i   = i;
                    lru_age = int'(tag_age[i]);
                end
            end else if (empty_i < 0) begin
                empty_i = i;
            end
        end
        if (hit_i >= 0) begin
            s     = hit_i;
            r.hit = 1'b1;
            thr   = int'(tag_age[s]);
        end else begin
            if (empty_i >= 0) begin
                s = empty_i;
            end else begin
                s         = (lru_i >= 0) ? lru_i : 0;
                r.evicted = 1'b1;
            end
            tag_valid[s] = 1'b1;
            tag_page[s]  = va[31:12];
            thr          = ENTRIES;  // a fresh fill counts as oldest
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != s && tag_valid[i] && int'(tag_age[i]) < thr &&
                tag_age[i] < 3'(ENTRIES - 1))
                tag_age[i] = tag_age[i] + 3'd1;
        end
        tag_age[s] = '0;
        r.slot     = 3'(s);
        return r;
    endfunction

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_page[i]  = '0;
            tag_age[i]   = '0;
        end
    end

    // scoreboard: transfers sampled at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                head = xlate(i_virtual_address);
                pending_xlate.push_back(cur_row_known ? cur_row_res : head);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_xlate.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: ",
                                 "hit=%0b ev=%0b slot=%0d pn=%05h off=%03h",
                                 o_hit, o_evicted, o_slot, o_page_number, o_page_offset);
                    mismatches <= mismatches + 1;
                end else begin
                    head = pending_xlate.pop_front();
                    if (o_hit !== head.hit || o_evicted !== head.evicted ||
                        o_slot !== head.slot || o_page_number !== head.page_number ||
                        o_page_offset !== head.page_offset) begin
                        if (mismatches < 10)
                            $display("mismatch: exp hit=%0b ev=%0b slot=%0d pn=%05h off=%03h",
                                     head.hit, head.evicted, head.slot, head.page_number,
                                     head.page_offset,
                                     " | got hit=%0b ev=%0b slot=%0d pn=%05h off=%03h",
                                     o_hit, o_evicted, o_slot,
                                     o_page_number, o_page_offset);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = calm || ($urandom_range(99) >= 13);
    end

    initial begin
        logic [19:0] pool [12];
        logic [31:0] va;
        int          sel;
        for (int i = 0; i < 12; i++)
            pool[i] = 20'($urandom());
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int k = 0; k < N_ROWS + N_RANDOM; k++) begin
            calm = (k >= 500 && k < 750);
            if (k < N_ROWS) begin
                va            = DIRECTED[k].va;
                cur_row_known = DIRECTED[k].known;
                cur_row_res   = DIRECTED[k].res;
            end else begin
                cur_row_known = 1'b0;
                if ($urandom_range(31) == 0)
                    pool[$urandom_range(11)] = 20'($urandom());
                sel = $urandom_range(99);
                if (sel < 60)
                    va = {pool[$urandom_range(11)], 12'($urandom())};
                else if (sel < 80)
                    va = {pool[$urandom_range(3)], 12'($urandom())};
                else
                    va = $urandom();
            end
            while (!calm && $urandom_range(99) < 13) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
            i_in_valid        = 1'b1;
            i_virtual_address = va;
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
        end
        i_in_valid = 1'b0;
        calm       = 1'b0;
        while (pending_xlate.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_xlate.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
